/* hdl/urs_pkg.sv */
// shared constants, register map and types for the radix-to-symbol converter
package urs_pkg;

    localparam int DATA_W    = 32;
    localparam int DIGIT_W   = 4;
    localparam int RADIX_W   = 5;
    localparam int SYM_W     = 8;
    localparam int ALPHA_W   = 64;
    localparam int REG_W     = 64;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 2;
    localparam int MAX_BASE  = 16;
    localparam int NUM_SYMS  = 16;
    localparam int STEP_W    = $clog2(DATA_W);

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_NUL   = 8'h00;

    localparam logic [REG_IDX_W-1:0] REG_BASE_SIZE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_LO  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_HI  = 2'd2;

    localparam logic [RADIX_W-1:0] RST_BASE_SIZE = 5'd10;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_LO  = 64'h3736_3534_3332_3130;
    localparam logic [ALPHA_W-1:0] RST_ALPHA_HI  = 64'h0000_0000_0000_3938;

    typedef struct packed {
        logic                done;
        logic [DATA_W-1:0]   quotient;
        logic [RADIX_W-1:0]  remainder;
    } t_div_res;

endpackage

/* hdl/urs_alpha.sv */
// alphabet decode: radix saturation, validity check and digit-to-symbol lookup
module urs_alpha (
    input  logic [urs_pkg::RADIX_W-1:0] i_base_size,
    input  logic [urs_pkg::ALPHA_W-1:0] i_alpha_lo,
    input  logic [urs_pkg::ALPHA_W-1:0] i_alpha_hi,
    input  logic [urs_pkg::DIGIT_W-1:0] i_digit,
    output logic [urs_pkg::RADIX_W-1:0] o_radix,
    output logic                        o_ok,
    output logic [urs_pkg::SYM_W-1:0]   o_symbol
);

    localparam int HALF = urs_pkg::NUM_SYMS / 2;

    logic [urs_pkg::SYM_W-1:0]    w_sym [urs_pkg::NUM_SYMS];
    logic [urs_pkg::NUM_SYMS-1:0] w_used;
    logic                         w_bad;

    always_comb begin
        for (int i = 0; i < HALF; i++) begin
            w_sym[i]        = i_alpha_lo[urs_pkg::SYM_W*i +: urs_pkg::SYM_W];
            w_sym[i + HALF] = i_alpha_hi[urs_pkg::SYM_W*i +: urs_pkg::SYM_W];
        end
    end

    assign o_radix = (i_base_size > urs_pkg::RADIX_W'(urs_pkg::MAX_BASE))
                   ? urs_pkg::RADIX_W'(urs_pkg::MAX_BASE) : i_base_size;

    always_comb begin
        for (int i = 0; i < urs_pkg::NUM_SYMS; i++) begin
            w_used[i] = urs_pkg::RADIX_W'(i) < o_radix;
        end
    end

    // reserved bytes and duplicate pairs among the symbols in use
    always_comb begin
        w_bad = 1'b0;
        for (int i = 0; i < urs_pkg::NUM_SYMS; i++) begin
            if (w_used[i] && (w_sym[i] == urs_pkg::SYM_NUL || w_sym[i] == urs_pkg::SYM_PLUS
                              || w_sym[i] == urs_pkg::SYM_MINUS)) begin
                w_bad = 1'b1;
            end
            for (int j = i + 1; j < urs_pkg::NUM_SYMS; j++) begin
                if (w_used[j] && w_sym[i] == w_sym[j]) begin
                    w_bad = 1'b1;
                end
            end
        end
    end

    assign o_ok     = (o_radix >= urs_pkg::RADIX_W'(2)) && !w_bad;
    assign o_symbol = w_sym[i_digit];

endmodule

/* hdl/urs_div.sv */
// shared restoring divider, one quotient bit per cycle
module urs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [urs_pkg::DATA_W-1:0]  i_dividend,
    input  logic [urs_pkg::RADIX_W-1:0] i_divisor,
    output urs_pkg::t_div_res           o_res
);

    logic                        r_run;
    logic                        r_done;
    logic [urs_pkg::STEP_W-1:0]  r_step;
    logic [urs_pkg::DATA_W-1:0]  r_quo;
    logic [urs_pkg::RADIX_W-1:0] r_rem;
    logic [urs_pkg::RADIX_W-1:0] r_div;

    logic [urs_pkg::RADIX_W:0]   w_trial;
    logic [urs_pkg::RADIX_W:0]   w_diff;
    logic                        w_ge;

    assign w_trial = {r_rem, r_quo[urs_pkg::DATA_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_run) begin
            r_step <= r_step + 1'b1;
            if (r_step == urs_pkg::STEP_W'(urs_pkg::DATA_W - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_run) begin
            r_quo <= {r_quo[urs_pkg::DATA_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[urs_pkg::RADIX_W-1:0] : w_trial[urs_pkg::RADIX_W-1:0];
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quo;
    assign o_res.remainder = r_rem;

endmodule

/* hdl/unsigned_radix_to_symbols.sv */
// top level: config registers, digit sequencer, digit store and symbol output
//
// channel   direction  signals                                   beat taken when
// command   in         start, busy, i_number                     start && !busy
// result    out        o_valid, o_symbol, o_last                 o_valid (one cycle)
// config    in/out     psel penable pwrite paddr pwdata prdata   psel && penable && pwrite
//
// each digit takes one full pass of the bit-serial divider, plus a handoff
// each symbol then passes the digit store read (S_RD), then the output register (S_EMIT)
// busy stays high from an accepted item until its final beat
// an invalid alphabet leaves the block idle and gives no beats
// synchronous active-low reset, no clearing pass; results cannot be stalled
module unsigned_radix_to_symbols #(
    parameter int MAX_DIGITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [urs_pkg::DATA_W-1:0]  i_number,
    output logic                        o_valid,
    output logic [urs_pkg::SYM_W-1:0]   o_symbol,
    output logic                        o_last,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [urs_pkg::ADDR_W-1:0]  paddr,
    input  logic [urs_pkg::REG_W-1:0]   pwdata,
    output logic [urs_pkg::REG_W-1:0]   prdata,
    output logic                        pready
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_EMIT
    } t_state;

    t_state                          r_state;
    logic [CNT_W-1:0]                r_count;
    logic [IDX_W-1:0]                r_idx;
    logic                            r_valid;
    logic [urs_pkg::SYM_W-1:0]       r_symbol;
    logic                            r_last;

    logic [urs_pkg::RADIX_W-1:0]     r_base_size;
    logic [urs_pkg::ALPHA_W-1:0]     r_alpha_lo;
    logic [urs_pkg::ALPHA_W-1:0]     r_alpha_hi;

    logic [urs_pkg::DIGIT_W-1:0]     r_mem [MAX_DIGITS];
    logic [urs_pkg::DIGIT_W-1:0]     r_rd_data;

    logic [urs_pkg::REG_IDX_W-1:0]   w_reg_idx;
    logic                            w_cfg_wr;
    logic [urs_pkg::RADIX_W-1:0]     w_radix;
    logic                            w_ok;
    logic [urs_pkg::SYM_W-1:0]       w_sym;
    logic                            w_accept;
    logic                            w_div_start;
    logic [urs_pkg::DATA_W-1:0]      w_dividend;
    urs_pkg::t_div_res               w_div;
    logic                            w_room;
    logic                            w_we;
    logic [IDX_W-1:0]                w_last_idx;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[urs_pkg::ADDR_W-1:3];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size <= urs_pkg::RST_BASE_SIZE;
            r_alpha_lo  <= urs_pkg::RST_ALPHA_LO;
            r_alpha_hi  <= urs_pkg::RST_ALPHA_HI;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                urs_pkg::REG_BASE_SIZE: r_base_size <= pwdata[urs_pkg::RADIX_W-1:0];
                urs_pkg::REG_ALPHA_LO:  r_alpha_lo  <= pwdata;
                urs_pkg::REG_ALPHA_HI:  r_alpha_hi  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            urs_pkg::REG_BASE_SIZE: prdata = urs_pkg::REG_W'(r_base_size);
            urs_pkg::REG_ALPHA_LO:  prdata = r_alpha_lo;
            urs_pkg::REG_ALPHA_HI:  prdata = r_alpha_hi;
            default:                prdata = '0;
        endcase
    end

    urs_alpha u_alpha (
        .i_base_size (r_base_size),
        .i_alpha_lo  (r_alpha_lo),
        .i_alpha_hi  (r_alpha_hi),
        .i_digit     (r_rd_data),
        .o_radix     (w_radix),
        .o_ok        (w_ok),
        .o_symbol    (w_sym)
    );

    // sequencer
    assign busy        = r_state != S_IDLE;
    assign w_accept    = start && !busy;
    assign w_room      = r_count < CNT_W'(MAX_DIGITS);
    assign w_we        = (r_state == S_DIV) && w_div.done && w_room;
    assign w_div_start = (w_accept && w_ok)
                      || ((r_state == S_DIV) && w_div.done && (w_div.quotient != '0));
    assign w_dividend  = (r_state == S_IDLE) ? i_number : w_div.quotient;
    assign w_last_idx  = w_room ? r_count[IDX_W-1:0] : IDX_W'(MAX_DIGITS - 1);

    urs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_radix),
        .o_res      (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && w_ok) begin
                        r_count <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        if (w_room) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (w_div.quotient == '0) begin
                            r_idx   <= w_last_idx;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_valid <= 1'b1;
                    if (r_idx == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT) begin
            r_symbol <= w_sym;
            r_last   <= r_idx == '0;
        end
    end

    // digit store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[IDX_W-1:0]] <= w_div.remainder[urs_pkg::DIGIT_W-1:0];
        end
        r_rd_data <= r_mem[r_idx];
    end

    assign o_valid  = r_valid;
    assign o_symbol = r_symbol;
    assign o_last   = r_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == S_DIV)
        else $error("divider finished outside of digit phase");

    a_beat_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == S_EMIT))
        else $error("result beat without emit step");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("still busy after final beat");

endmodule
